@@ src/bscu_pkg.sv @@
// shared types, constants and helpers for the barometric compensation unit
// no dependencies
package bscu_pkg;

	localparam int DW = 32;
	localparam int FIFO_DEPTH = 4;

	localparam logic [2:0] REG_AC1_AC2  = 3'd0;
	localparam logic [2:0] REG_AC3_AC4  = 3'd1;
	localparam logic [2:0] REG_AC5_AC6  = 3'd2;
	localparam logic [2:0] REG_B1_B2    = 3'd3;
	localparam logic [2:0] REG_MC_MD    = 3'd4;
	localparam logic [2:0] REG_OSS      = 3'd5;

	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] K_3038    = 32'd3038;
	localparam logic [31:0] K_M7357   = 32'hFFFF_E343;
	localparam logic [31:0] K_3791    = 32'd3791;
	localparam logic [31:0] K_50000   = 32'd50000;
	localparam logic [31:0] K_32768   = 32'd32768;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [23:0] raw_pressure;
	} bscu_in_t;

	typedef struct packed {
		logic signed [31:0] temperature_tenths;
		logic signed [31:0] pressure_pa;
		logic               divide_error;
	} bscu_out_t;

	// calibration words, already extended to 32 bits
	typedef struct packed {
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [1:0]  oss;
	} bscu_cal_t;

	typedef struct packed {
		logic [31:0] x1;
		logic [31:0] den;
		logic [23:0] up;
	} bscu_fe_t;

	typedef struct packed {
		logic [31:0] x1, den, num, dvs;
		logic [23:0] up;
		logic        neg, err;
		logic [31:0] temp, b6, sq, m1, m2, m3, m4, b3, t4, b4, d2, b7, p, sqp, x2m, x1m;
	} bscu_ctx_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input int s);
		asr = 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage

@@ src/bscu_div.sv @@
// pipelined unsigned 32/32 divider, one quotient bit per stage
// depends on bscu_pkg
module bscu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [31:0]       num,
	input  logic [31:0]       dvs,
	input  bscu_pkg::bscu_ctx_t in_ctx,
	output logic              out_valid,
	output logic [31:0]       quo,
	output bscu_pkg::bscu_ctx_t out_ctx
);
	import bscu_pkg::*;

	logic                v_q   [DW];
	logic [31:0]         n_q   [DW];
	logic [31:0]         d_q   [DW];
	logic [31:0]         r_q   [DW];
	logic [31:0]         qt_q  [DW];
	bscu_ctx_t           c_q   [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic        v_in;
		logic [31:0] n_in, d_in, r_in, qt_in;
		bscu_ctx_t   c_in;
		logic [32:0] trial;
		logic        ge;
		logic [31:0] r_nx, qt_nx;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign n_in  = num;
			assign d_in  = dvs;
			assign r_in  = '0;
			assign qt_in = '0;
			assign c_in  = in_ctx;
		end else begin : g_next
			assign v_in  = v_q[k-1];
			assign n_in  = n_q[k-1];
			assign d_in  = d_q[k-1];
			assign r_in  = r_q[k-1];
			assign qt_in = qt_q[k-1];
			assign c_in  = c_q[k-1];
		end

		always_comb begin
			trial = {r_in, n_in[31]};
			ge    = trial >= {1'b0, d_in};
			r_nx  = ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
			qt_nx = {qt_in[30:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[k]  <= {n_in[30:0], 1'b0};
				d_q[k]  <= d_in;
				r_q[k]  <= r_nx;
				qt_q[k] <= qt_nx;
				c_q[k]  <= c_in;
			end
		end
	end

	assign out_valid = v_q[DW-1];
	assign quo       = qt_q[DW-1];
	assign out_ctx   = c_q[DW-1];

endmodule

@@ src/bscu_front.sv @@
// front end: takes sensor frames, computes x1 and the temperature divisor
// depends on bscu_pkg
module bscu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  bscu_pkg::bscu_cal_t cal,
	input  logic                in_valid,
	output logic                in_ready,
	input  bscu_pkg::bscu_in_t  in_data,
	output logic                push,
	output bscu_pkg::bscu_fe_t  push_data,
	input  logic                full
);
	import bscu_pkg::*;

	logic        v_s1;
	logic [31:0] prod_s1;
	logic [23:0] up_s1;
	logic [31:0] x1;

	assign in_ready = !v_s1 || !full;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s1 <= 32'(({16'd0, in_data.raw_temperature} - cal.ac6) * cal.ac5);
			up_s1   <= in_data.raw_pressure >> (4'd8 - {2'd0, cal.oss});
		end
	end

	always_comb begin
		x1             = asr(prod_s1, 15);
		push_data.x1   = x1;
		push_data.den  = x1 + cal.md;
		push_data.up   = up_s1;
	end

endmodule

@@ src/bscu_fifo.sv @@
// four-entry queue between front end and back end
// depends on bscu_pkg
module bscu_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bscu_pkg::bscu_fe_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output bscu_pkg::bscu_fe_t pop_data
);
	import bscu_pkg::*;

	bscu_fe_t                        mem_q [FIFO_DEPTH];
	logic [$clog2(FIFO_DEPTH)-1:0]   wp_q, rp_q;
	logic [$clog2(FIFO_DEPTH):0]     cnt_q;

	assign full      = cnt_q == ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(FIFO_DEPTH){1'b0}}, push}
				- {{$clog2(FIFO_DEPTH){1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

@@ src/bscu_back.sv @@
// back end: compensation pipeline with two pipelined dividers and output register
// depends on bscu_pkg, bscu_div
module bscu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bscu_pkg::bscu_cal_t cal,
	input  logic                q_valid,
	input  bscu_pkg::bscu_fe_t  q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output bscu_pkg::bscu_out_t out_data
);
	import bscu_pkg::*;

	logic      en;
	logic      out_valid_q;
	bscu_out_t out_q;

	logic      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	bscu_ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	bscu_ctx_t c_in, d1_ctx, d2_ctx;
	bscu_ctx_t n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9, n_s10;
	bscu_out_t n_out;
	logic      d1_v, d2_v;
	logic [31:0] d1_q, d2_q, num2, x2, b5, x3a, x3b, pf;

	assign en        = !out_valid_q || out_ready;
	assign pop       = en && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// stage 1: signed divide operands as magnitudes
	always_comb begin
		c_in      = '0;
		c_in.x1   = q_data.x1;
		c_in.den  = q_data.den;
		c_in.up   = q_data.up;
		c_in.neg  = cal.mc[20] ^ q_data.den[31];
		c_in.num  = cal.mc[20] ? 32'(0 - (cal.mc << 11)) : (cal.mc << 11);
		c_in.dvs  = q_data.den[31] ? 32'(0 - q_data.den) : q_data.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= d1_v; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= d2_v; v_s9 <= v_s8; v_s10 <= v_s9;
			out_valid_q <= v_s10;
		end
	end

	bscu_div u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(c_s1.num), .dvs(c_s1.dvs), .in_ctx(c_s1),
		.out_valid(d1_v), .quo(d1_q), .out_ctx(d1_ctx)
	);

	assign num2 = c_s7.b7[31] ? c_s7.b7 : {c_s7.b7[30:0], 1'b0};

	bscu_div u_div_p (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7),
		.num(num2), .dvs(c_s7.b4), .in_ctx(c_s7),
		.out_valid(d2_v), .quo(d2_q), .out_ctx(d2_ctx)
	);

	always_comb begin
		x2  = d1_ctx.neg ? 32'(0 - d1_q) : d1_q;
		b5  = d1_ctx.x1 + x2;
		x3a = asr(c_s4.m1, 11) + asr(c_s4.m2, 11);
		x3b = asr(asr(c_s4.m3, 13) + asr(c_s4.m4, 16) + 32'd2, 2);
		pf  = c_s10.p + asr(asr(c_s10.x1m, 16) + asr(c_s10.x2m, 16) + K_3791, 4);

		n_s2      = d1_ctx;
		n_s2.err  = d1_ctx.den == '0;
		n_s2.temp = asr(b5 + 32'd8, 4);
		n_s2.b6   = b5 - B6_OFFSET;
		n_s3      = c_s2;
		n_s3.sq   = asr(32'(c_s2.b6 * c_s2.b6), 12);
		n_s4      = c_s3;
		n_s4.m1   = 32'(cal.b2 * c_s3.sq);
		n_s4.m2   = 32'(cal.ac2 * c_s3.b6);
		n_s4.m3   = 32'(cal.ac3 * c_s3.b6);
		n_s4.m4   = 32'(cal.b1 * c_s3.sq);
		n_s5      = c_s4;
		n_s5.b3   = asr(((32'(cal.ac1 << 2) + x3a) << cal.oss) + 32'd2, 2);
		n_s5.t4   = x3b + K_32768;
		n_s6      = c_s5;
		n_s6.b4   = 32'(cal.ac4 * c_s5.t4) >> 15;
		n_s6.d2   = {8'd0, c_s5.up} - c_s5.b3;
		n_s7      = c_s6;
		n_s7.err  = c_s6.err || (c_s6.b4 == '0);
		n_s7.b7   = 32'(c_s6.d2 * (K_50000 >> cal.oss));
		n_s8      = d2_ctx;
		n_s8.p    = d2_ctx.b7[31] ? {d2_q[30:0], 1'b0} : d2_q;
		n_s9      = c_s8;
		n_s9.sqp  = 32'(asr(c_s8.p, 8) * asr(c_s8.p, 8));
		n_s9.x2m  = 32'(K_M7357 * c_s8.p);
		n_s10     = c_s9;
		n_s10.x1m = 32'(c_s9.sqp * K_3038);

		n_out.divide_error       = c_s10.err;
		n_out.temperature_tenths = c_s10.err ? '0 : c_s10.temp;
		n_out.pressure_pa        = c_s10.err ? '0 : pf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pop) c_s1 <= c_in;
			c_s2  <= n_s2;
			c_s3  <= n_s3;
			c_s4  <= n_s4;
			c_s5  <= n_s5;
			c_s6  <= n_s6;
			c_s7  <= n_s7;
			c_s8  <= n_s8;
			c_s9  <= n_s9;
			c_s10 <= n_s10;
			out_q <= n_out;
		end
	end

endmodule

@@ src/barometric_sensor_compensation_unit.sv @@
// top level of the barometric compensation unit: configuration registers,
// front end, queue and back end; depends on bscu_pkg, bscu_front, bscu_fifo, bscu_back
//
// usage:
//  - write the five calibration words and the oversampling code through
//    cfg_we / cfg_index / cfg_data while no frame is in flight
//  - frames enter on in_valid/in_ready (raw temperature, raw pressure)
//  - results leave on out_valid/out_ready: temperature in 0.1 C, pressure
//    in Pa, and divide_error with both values zero when a divisor was zero
//  - throughput: one frame per cycle while out_ready stays high
//  - from acceptance to out_valid a frame passes the front stage, the queue
//    and the arithmetic stages around the two 32-stage pipelined dividers
//  - reset clears all valid bits and the calibration registers to zero
//  - when the receiver stalls the whole back end holds; the four-entry
//    queue and the front stage keep taking frames until the queue fills
module barometric_sensor_compensation_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  bscu_pkg::bscu_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bscu_pkg::bscu_out_t out_data
);
	import bscu_pkg::*;

	logic [31:0] r0_q, r1_q, r2_q, r3_q, r4_q;
	logic [1:0]  oss_q;
	bscu_cal_t   cal;
	logic        push, full, pop, not_empty;
	bscu_fe_t    push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0; r4_q <= '0;
			oss_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AC1_AC2: r0_q  <= cfg_data;
				REG_AC3_AC4: r1_q  <= cfg_data;
				REG_AC5_AC6: r2_q  <= cfg_data;
				REG_B1_B2:   r3_q  <= cfg_data;
				REG_MC_MD:   r4_q  <= cfg_data;
				REG_OSS:     oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.ac1 = sx16(r0_q[31:16]);
		cal.ac2 = sx16(r0_q[15:0]);
		cal.ac3 = sx16(r1_q[31:16]);
		cal.ac4 = {16'd0, r1_q[15:0]};
		cal.ac5 = {16'd0, r2_q[31:16]};
		cal.ac6 = {16'd0, r2_q[15:0]};
		cal.b1  = sx16(r3_q[31:16]);
		cal.b2  = sx16(r3_q[15:0]);
		cal.mc  = sx16(r4_q[31:16]);
		cal.md  = sx16(r4_q[15:0]);
		cal.oss = oss_q;
	end

	bscu_front u_front (
		.clk(clk), .arst_n(arst_n), .cal(cal),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.push(push), .push_data(push_data), .full(full)
	);

	bscu_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .not_empty(not_empty), .pop_data(pop_data)
	);

	bscu_back u_back (
		.clk(clk), .arst_n(arst_n), .cal(cal),
		.q_valid(not_empty), .q_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

@@ src/bscu_checker.sv @@
// port-level checks for the barometric compensation unit, bound to the top
// depends on bscu_pkg
module bscu_assert (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bscu_pkg::bscu_out_t out_data
);

	// a stalled request keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_error |->
			out_data.temperature_tenths == 0 && out_data.pressure_pa == 0)
		else $error("divide error with nonzero result");

	// input side only backs up after an output stall
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without output stall");

endmodule

bind barometric_sensor_compensation_unit bscu_assert u_bscu_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ bench/bscu_checker.sv @@
// checker for the barometric compensation unit: follows the configuration port,
// predicts each compensated reading and compares results in order; depends on bscu_pkg
module bscu_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  bscu_pkg::bscu_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  bscu_pkg::bscu_out_t out_data,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bscu_pkg::*;

	logic [31:0] cal [6];
	bscu_out_t   readings_due [$];

	function automatic logic [31:0] shr_arith(input logic [31:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] sign16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// signed divide, quotient truncated toward zero
	function automatic logic [31:0] quot_trunc(input logic [31:0] n, input logic [31:0] d);
		logic [31:0] an, ad, q;
		an = n[31] ? 32'd0 - n : n;
		ad = d[31] ? 32'd0 - d : d;
		q = an / ad;
		return (n[31] != d[31]) ? 32'd0 - q : q;
	endfunction

	function automatic bscu_out_t compensate(input bscu_in_t f);
		bscu_out_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, up, t, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
		logic [1:0]  oss;
		ac1 = sign16(cal[REG_AC1_AC2][31:16]);
		ac2 = sign16(cal[REG_AC1_AC2][15:0]);
		ac3 = sign16(cal[REG_AC3_AC4][31:16]);
		ac4 = {16'd0, cal[REG_AC3_AC4][15:0]};
		ac5 = {16'd0, cal[REG_AC5_AC6][31:16]};
		ac6 = {16'd0, cal[REG_AC5_AC6][15:0]};
		b1 = sign16(cal[REG_B1_B2][31:16]);
		b2 = sign16(cal[REG_B1_B2][15:0]);
		mc = sign16(cal[REG_MC_MD][31:16]);
		md = sign16(cal[REG_MC_MD][15:0]);
		oss = cal[REG_OSS][1:0];
		r = '0;
		ut = {16'd0, f.raw_temperature};
		up = {8'd0, f.raw_pressure} >> (4'd8 - oss);
		t = (ut - ac6) * ac5;
		x1 = shr_arith(t, 15);
		den = x1 + md;
		if (den == 32'd0) begin
			r.divide_error = 1'b1;
			return r;
		end
		x2 = quot_trunc(mc * 32'd2048, den);
		b5 = x1 + x2;
		r.temperature_tenths = shr_arith(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		t = b6 * b6;
		sq = shr_arith(t, 12);
		t = b2 * sq;
		x1 = shr_arith(t, 11);
		t = ac2 * b6;
		x2 = shr_arith(t, 11);
		x3 = x1 + x2;
		t = (ac1 * 32'd4 + x3) << oss;
		b3 = shr_arith(t + 32'd2, 2);
		t = ac3 * b6;
		x1 = shr_arith(t, 13);
		t = b1 * sq;
		x2 = shr_arith(t, 16);
		x3 = shr_arith(x1 + x2 + 32'd2, 2);
		t = ac4 * (x3 + 32'd32768);
		b4 = t >> 15;
		if (b4 == 32'd0) begin
			r = '0;
			r.divide_error = 1'b1;
			return r;
		end
		b7 = (up - b3) * (32'd50000 >> oss);
		if (!b7[31])
			p = (b7 << 1) / b4;
		else
			p = (b7 / b4) << 1;
		x1 = shr_arith(p, 8);
		x1 = x1 * x1;
		t = x1 * 32'd3038;
		x1 = shr_arith(t, 16);
		t = 32'hFFFF_E343 * p;
		x2 = shr_arith(t, 16);
		p = p + shr_arith(x1 + x2 + 32'd3791, 4);
		r.pressure_pa = p;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = readings_due.size();

	always @(posedge clk or negedge arst_n) begin
		bscu_out_t want;
		if (!arst_n) begin
			foreach (cal[i]) cal[i] = '0;
			errors = 0;
		end else begin
			if (cfg_we && cfg_index < 3'd6)
				cal[cfg_index] = (cfg_index == REG_OSS) ? {30'd0, cfg_data[1:0]} : cfg_data;
			if (in_valid && in_ready)
				readings_due.push_back(compensate(in_data));
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					report("unexpected request result", out_data.pressure_pa, 32'd0);
				end else begin
					want = readings_due.pop_front();
					if (out_data.temperature_tenths !== want.temperature_tenths)
						report("temperature_tenths", out_data.temperature_tenths,
							want.temperature_tenths);
					if (out_data.pressure_pa !== want.pressure_pa)
						report("pressure_pa", out_data.pressure_pa, want.pressure_pa);
					if (out_data.divide_error !== want.divide_error)
						report("divide_error", out_data.divide_error, want.divide_error);
				end
			end
		end
	end

endmodule

@@ bench/barometric_sensor_compensation_unit_test.sv @@
// top of the compensation unit testbench: clock, reset, calibration phases,
// bursty requests and receiver stalls; depends on bscu_pkg, bscu_checker and the unit
module barometric_sensor_compensation_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bscu_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	bscu_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	bscu_out_t   out_data;
	int          errors, pending;
	int          squeeze_req = 0;
	int          idle_cycles = 0;

	barometric_sensor_compensation_unit u_top (.*);

	bscu_checker u_checker (.*);

	always #10 clk = ~clk;

	// drives one request and holds it until accepted
	task automatic send(input logic [15:0] t, input logic [23:0] p);
		in_valid <= 1'b1;
		in_data <= '{raw_temperature: t, raw_pressure: p};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_cal(input logic [31:0] w [6]);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= w[i];
			@(posedge clk);
		end
		// out of range index must be ignored
		cfg_index <= 3'($urandom_range(6, 7));
		cfg_data <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int count, input bit mid_pause, input bit fill_up);
		int sent, burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				send(16'($urandom()), 24'($urandom()));
				sent++;
				if (fill_up && sent == 20)
					squeeze_req <= squeeze_req + 1;
				if (mid_pause && sent == count / 2)
					drain();
			end
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		int mode, span, squeeze_seen;
		squeeze_seen = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 200);
			for (int i = 0; i < span; i++) begin
				if (squeeze_req != squeeze_seen) begin
					squeeze_seen = squeeze_req;
					out_ready <= 1'b0;
					repeat (400) @(posedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [31:0] w [6];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: zero divisor on every request
		send(16'h0000, 24'h000000);
		send(16'hFFFF, 24'hFFFFFF);
		send(16'h6CFA, 24'h5D2300);
		drain();

		// typical calibration set, oversampling 0
		w = '{{16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {16'hDDE9, 16'd2868}, 32'd0};
		load_cal(w);
		send(16'd27898, 24'd23843 << 8);
		send(16'h0000, 24'h000000);
		send(16'hFFFF, 24'hFFFFFF);
		send(16'h8000, 24'h800000);
		send(16'h7FFF, 24'h7FFFFF);
		random_traffic(150, 1'b1, 1'b0);
		drain();

		// all ones, oversampling 3
		w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF};
		load_cal(w);
		send(16'h0000, 24'h000000);
		send(16'hFFFF, 24'hFFFFFF);
		random_traffic(150, 1'b0, 1'b1);
		drain();

		// ac4 zero gives a zero b4 divisor, oversampling 1
		w = '{32'h7FFF_8000, 32'h8000_0000, 32'h8000_7FFF, 32'h7FFF_8000,
			32'h8000_7FFF, 32'd1};
		load_cal(w);
		send(16'h1234, 24'hABCDEF);
		send(16'hFFFF, 24'h000000);
		random_traffic(60, 1'b0, 1'b0);
		drain();

		// extremes the other way, oversampling 2
		w = '{32'h8000_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_7FFF,
			32'h7FFF_8000, 32'd2};
		load_cal(w);
		send(16'h0000, 24'hFFFFFF);
		random_traffic(100, 1'b0, 1'b0);
		drain();

		// random calibration, plus jittered typical sets
		for (int ph = 0; ph < 6; ph++) begin
			foreach (w[i]) w[i] = $urandom();
			if (ph[0])
				w = '{{16'd408 + 16'($urandom_range(0, 200)), 16'hFFB8},
					{16'hC7D1, 16'd32741 - 16'($urandom_range(0, 900))},
					{16'd32757, 16'd23153}, {16'd6190, 16'd4},
					{16'hDDE9, 16'd2868 + 16'($urandom_range(0, 300))}, 32'd0};
			w[REG_OSS] = $urandom();
			load_cal(w);
			random_traffic(150, ph == 2, ph == 4);
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
